// ----- src/gsmf_pkg.sv -----
// Shared constants and types of the gated sliding median filter.
package gsmf_pkg;

    // Number of samples held in the sliding window (range 1 to 64).
    localparam int WINDOW_SIZE = 50;

    // Sample and result width.
    localparam int DATA_W = 19;

    // Window address and entry count widths.
    localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CW = $clog2(WINDOW_SIZE + 1);

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = CFG_IDX_W'(1);

    // Register reset values.
    localparam logic signed [DATA_W-1:0] LOW_LIMIT_RESET  = 19'sd0;
    localparam logic signed [DATA_W-1:0] HIGH_LIMIT_RESET = 19'sd160000;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic [AW-1:0]            t_addr;
    typedef logic [CW-1:0]            t_count;

endpackage

// ----- src/gsmf_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module gsmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; a read of the address being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/gated_sliding_median_filter.sv -----
// Top level of the gated sliding median filter: window, sorted copy and median sequencer.
//
// Each accepted item writes a signed distance sample (1/16 cm) over the oldest
// of the last WINDOW_SIZE samples and returns one result: the median of the
// samples lying between the low and high limits, in 1/32 cm (twice the
// middle value, or the sum of the two middle values), saturated at zero, with
// any_valid low and a zero median when no sample is in range. Besides the
// circular window the block keeps a sorted copy of it in a second RAM. The
// next item is accepted only once the pass for the last one has ended, and
// that pass waits at its end while the previous result still sits in the
// output register: a single merge pass walks the sorted RAM one entry per
// cycle through its one read port, dropping the evicted sample, inserting the
// new one and counting entries below the low limit and up to the high limit,
// after which two reads fetch the middle values. Both RAMs start as all
// zeros through per-entry valid bits, so no clearing pass follows reset. The
// result sits in an output register, so the next item is taken while it
// waits. Configuration is accepted at any time and must be written only
// while the block is idle.
module gated_sliding_median_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [gsmf_pkg::DATA_W-1:0] i_distance_sample,
    // Result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [gsmf_pkg::DATA_W-1:0]        o_median_distance,
    output logic                               o_any_valid,
    // Configuration channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gsmf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gsmf_pkg::DATA_W-1:0]        i_cfg_data
);
    localparam int WS = gsmf_pkg::WINDOW_SIZE;
    localparam int AW = gsmf_pkg::AW;
    localparam int CW = gsmf_pkg::CW;
    localparam int DW = gsmf_pkg::DATA_W;
    localparam logic [AW-1:0] LAST = AW'(WS - 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OLD   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_END   = 4'd4;
    localparam logic [3:0] S_SEL   = 4'd5;
    localparam logic [3:0] S_RD1   = 4'd6;
    localparam logic [3:0] S_RD2   = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;

    logic [3:0]              r_state;
    gsmf_pkg::t_addr         r_wp;
    logic [WS-1:0]           r_win_vld;
    logic [WS-1:0]           r_srt_vld;
    logic                    r_win_rv;
    logic                    r_srt_rv;
    gsmf_pkg::t_sample       r_min;
    gsmf_pkg::t_sample       r_max;
    gsmf_pkg::t_sample       r_x;
    gsmf_pkg::t_sample       r_old;
    gsmf_pkg::t_sample       r_h;
    gsmf_pkg::t_sample       r_m1;
    logic                    r_ins;
    logic                    r_rem;
    gsmf_pkg::t_addr         r_ra;
    gsmf_pkg::t_addr         r_di;
    gsmf_pkg::t_addr         r_idx2;
    logic                    r_dv;
    gsmf_pkg::t_count        r_lo;
    gsmf_pkg::t_count        r_le;
    logic                    r_any;
    logic                    r_ovld;
    logic [DW-1:0]           r_med;
    logic                    r_anyo;

    logic [DW-1:0]           win_rdata;
    logic [DW-1:0]           srt_rdata;
    gsmf_pkg::t_sample       old_val;
    gsmf_pkg::t_sample       d;
    logic                    srt_we;
    gsmf_pkg::t_addr         srt_waddr;
    gsmf_pkg::t_sample       srt_wdata;
    logic                    n_ins;
    logic                    n_rem;
    gsmf_pkg::t_sample       n_h;
    gsmf_pkg::t_count        lo_inc;
    gsmf_pkg::t_count        le_inc;
    gsmf_pkg::t_count        cnt;
    gsmf_pkg::t_count        idx1;
    gsmf_pkg::t_count        idx2;
    logic signed [DW:0]      sum;
    logic [DW-1:0]           med_sat;
    logic                    in_acc;
    logic                    out_acc;
    logic                    res_load;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_acc  = o_out_valid && i_out_ready;
    assign res_load = (r_state == S_SUM) && (!r_ovld || i_out_ready);

    // Circular window of raw samples
    gsmf_ram #(
        .WIDTH (DW),
        .DEPTH (WS)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_OLD),
        .i_waddr (r_wp),
        .i_wdata (r_x),
        .i_raddr (r_wp),
        .o_rdata (win_rdata)
    );

    // Sorted copy of the window
    gsmf_ram #(
        .WIDTH (DW),
        .DEPTH (WS)
    ) u_srt_ram (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_waddr),
        .i_wdata (srt_wdata),
        .i_raddr (r_ra),
        .o_rdata (srt_rdata)
    );

    // Entries never written read as zero
    assign old_val = r_win_rv ? $signed(win_rdata) : '0;
    assign d       = r_srt_rv ? $signed(srt_rdata) : '0;

    // Merge step: drop the evicted sample, insert the new one, one write a cycle
    always_comb begin
        srt_we    = 1'b0;
        srt_waddr = r_di;
        srt_wdata = r_x;
        n_ins     = r_ins;
        n_rem     = r_rem;
        n_h       = r_h;
        if (r_dv) begin
            if (!r_ins && !r_rem) begin
                if (r_x <= d) begin
                    srt_we = 1'b1;
                    n_ins  = 1'b1;
                    if (d == r_old) begin
                        n_rem = 1'b1;
                    end else begin
                        n_h = d;
                    end
                end else if (d == r_old) begin
                    n_rem = 1'b1;
                end
            end else if (r_ins && !r_rem) begin
                // Shift up by one: write the held entry, hold this one
                srt_we    = 1'b1;
                srt_wdata = r_h;
                if (d == r_old) begin
                    n_rem = 1'b1;
                end else begin
                    n_h = d;
                end
            end else if (!r_ins && r_rem) begin
                // Shift down by one until the new sample fits, then place it
                srt_we    = 1'b1;
                srt_waddr = r_di - 1'b1;
                if (r_x <= d) begin
                    n_ins = 1'b1;
                end else begin
                    srt_wdata = d;
                end
            end
        end else if (r_state == S_OLD) begin
            // Start a new pass with nothing dropped or placed
            n_ins = 1'b0;
            n_rem = 1'b0;
        end else if (r_state == S_END) begin
            // Close the pass at the top entry
            srt_waddr = LAST;
            if (r_rem && !r_ins) begin
                srt_we    = 1'b1;
                srt_wdata = r_x;
            end else if (r_ins && !r_rem) begin
                srt_we    = 1'b1;
                srt_wdata = r_h;
            end
            n_ins = 1'b1;
            n_rem = 1'b1;
        end
    end

    // Limit counts over the streamed entries
    assign lo_inc = r_lo + {{(CW-1){1'b0}}, (d < r_min)};
    assign le_inc = r_le + {{(CW-1){1'b0}}, (d <= r_max)};

    // Valid entries occupy sorted ranks lo up to le - 1
    assign cnt  = (r_le > r_lo) ? (r_le - r_lo) : '0;
    assign idx1 = r_lo + ((cnt - 1'b1) >> 1);
    assign idx2 = r_lo + (cnt >> 1);

    // Sum of the two middle values, saturated at zero
    assign sum     = {r_m1[DW-1], r_m1} + {d[DW-1], d};
    assign med_sat = sum[DW] ? '0 : sum[DW-1:0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= gsmf_pkg::LOW_LIMIT_RESET;
            r_max <= gsmf_pkg::HIGH_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gsmf_pkg::REG_LOW_LIMIT:  r_min <= $signed(i_cfg_data);
                gsmf_pkg::REG_HIGH_LIMIT: r_max <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Read-side valid bits follow the registered RAM reads
    always_ff @(posedge i_clk) begin
        r_win_rv <= r_win_vld[r_wp];
        r_srt_rv <= r_srt_vld[r_ra];
        r_di     <= r_ra;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_win_vld <= '0;
            r_srt_vld <= '0;
            r_ins     <= 1'b0;
            r_rem     <= 1'b0;
            r_dv      <= 1'b0;
            r_ra      <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_dv  <= (r_state == S_SCAN);
            r_ins <= n_ins;
            r_rem <= n_rem;
            r_h   <= n_h;
            if (srt_we) begin
                r_srt_vld[srt_waddr] <= 1'b1;
            end
            if (r_dv) begin
                r_lo <= lo_inc;
                r_le <= le_inc;
            end
            // Hold the result until taken; load a new one once the register frees
            if (res_load) begin
                r_ovld <= 1'b1;
            end else if (out_acc) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x     <= i_distance_sample;
                        r_state <= S_OLD;
                    end
                end
                S_OLD: begin
                    // Capture the evicted sample, store the new one, start the pass
                    r_old            <= old_val;
                    r_win_vld[r_wp]  <= 1'b1;
                    r_wp             <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
                    r_ra             <= '0;
                    r_lo             <= '0;
                    r_le             <= '0;
                    r_state          <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_ra == LAST) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_ra <= r_ra + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_END;
                end
                S_END: begin
                    // Counts were taken over the old contents: swap evicted for new
                    r_lo <= r_lo - {{(CW-1){1'b0}}, (r_old < r_min)}
                                 + {{(CW-1){1'b0}}, (r_x < r_min)};
                    r_le <= r_le - {{(CW-1){1'b0}}, (r_old <= r_max)}
                                 + {{(CW-1){1'b0}}, (r_x <= r_max)};
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_any   <= (cnt != '0);
                    r_ra    <= (cnt != '0) ? idx1[AW-1:0] : '0;
                    r_idx2  <= (cnt != '0) ? idx2[AW-1:0] : '0;
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_ra    <= r_idx2;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_m1    <= d;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    // Load the result once the output register is free
                    if (res_load) begin
                        r_med   <= r_any ? med_sat : '0;
                        r_anyo  <= r_any;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_ovld;
    assign o_median_distance = r_med;
    assign o_any_valid       = r_anyo;
    assign o_cfg_ready       = 1'b1;

`ifndef SYNTHESIS
    // The merge pass must have dropped the evicted sample and placed the new one
    a_merge_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> (r_ins && r_rem))
        else $error("sorted window merge incomplete");

    // A result without valid entries carries a zero median
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_any_valid) |-> (o_median_distance == '0))
        else $error("nonzero median with no valid entry");

    // One item at a time: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while busy");

    // Window write position stays inside the window
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= LAST))
        else $error("write position out of range");
`endif

endmodule
